// ----- src/aph_pkg.sv -----
package aph_pkg;

  // Field widths fixed by the port definition
  localparam int ANGLE_W    = 16;
  localparam int IDX_PORT_W = 6;
  localparam int CFG_W      = 7;
  localparam int SQ_W       = 40;

  localparam logic [CFG_W-1:0] BIN_COUNT_RESET = 7'd36;
  localparam logic [SQ_W-1:0]  SQ_MAX          = '1;

  // Angle range in whole degrees
  localparam int HALF_TURN_DEG = 180;
  localparam int FULL_TURN_DEG = 360;

  // 360 = 45 << 3: the power of two is a shift, the 45 a reciprocal multiply.
  // floor(q * RECIP / 2^RECIP_SHIFT) equals floor(q / 45) for q below 74898.
  localparam int TURN_SHIFT  = 3;
  localparam int DIV_BASE    = 45;
  localparam int RECIP       = 23302;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 20;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } aph_op_t;

  // Control that travels with each word down the pipeline
  typedef struct packed {
    logic    valid;
    aph_op_t op;
    logic    oob;
  } aph_tag_t;

endpackage

// ----- src/aph_if.sv -----
interface aph_cfg_if import aph_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] bin_count;

  modport source (output valid, output bin_count, input ready);
  modport sink   (input valid, input bin_count, output ready);
endinterface

interface aph_req_if import aph_pkg::*; ();
  logic                        valid;
  logic                        ready;
  aph_op_t                     op;
  logic signed [ANGLE_W-1:0]   angle_first;
  logic signed [ANGLE_W-1:0]   angle_second;
  logic [IDX_PORT_W-1:0]       read_row;
  logic [IDX_PORT_W-1:0]       read_col;

  modport source (output valid, output op, output angle_first, output angle_second,
                  output read_row, output read_col, input ready);
  modport sink   (input valid, input op, input angle_first, input angle_second,
                  input read_row, input read_col, output ready);
endinterface

interface aph_rsp_if import aph_pkg::*; #(parameter int COUNT_WIDTH = 20) ();
  logic                   valid;
  logic                   ready;
  logic [IDX_PORT_W-1:0]  bin_row;
  logic [IDX_PORT_W-1:0]  bin_col;
  logic [COUNT_WIDTH-1:0] bin_value;
  logic [COUNT_WIDTH-1:0] peak_count;
  logic [COUNT_WIDTH-1:0] total_samples;
  logic [SQ_W-1:0]        square_sum;
  logic                   overflow;

  modport source (output valid, output bin_row, output bin_col, output bin_value,
                  output peak_count, output total_samples, output square_sum,
                  output overflow, input ready);
  modport sink   (input valid, input bin_row, input bin_col, input bin_value,
                  input peak_count, input total_samples, input square_sum,
                  input overflow, output ready);
endinterface

// ----- src/aph_bin_map.sv -----
// Two-stage binning pipeline: angle offset and scale by bin count, then
// divide by the turn (shift plus reciprocal multiply) and clamp to the grid.
module aph_bin_map import aph_pkg::*; #(
  parameter int MAX_BINS        = 64,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int IDX_W           = 6,
  parameter int NB_W            = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      load,
  input  aph_op_t                   op,
  input  logic signed [ANGLE_W-1:0] angle_first,
  input  logic signed [ANGLE_W-1:0] angle_second,
  input  logic [IDX_PORT_W-1:0]     read_row,
  input  logic [IDX_PORT_W-1:0]     read_col,
  input  logic [CFG_W-1:0]          bin_count,
  output aph_tag_t                  tag,
  output logic [2*IDX_W-1:0]        addr,
  output logic [IDX_PORT_W-1:0]     echo_row,
  output logic [IDX_PORT_W-1:0]     echo_col
);

  localparam int HALF = HALF_TURN_DEG << ANGLE_FRAC_BITS;
  localparam int FULL = FULL_TURN_DEG << ANGLE_FRAC_BITS;
  localparam int T_W  = $clog2(FULL + (1 << (ANGLE_W - 1))) + 1;
  localparam int TC_W = $clog2(FULL);
  localparam int P_W  = NB_W + TC_W;
  localparam int SH   = ANGLE_FRAC_BITS + TURN_SHIFT;
  localparam int Q_W  = $clog2(MAX_BINS * DIV_BASE);
  localparam int D_W  = Q_W + RECIP_W;

  logic [NB_W-1:0]          nb;
  logic                     oob;
  logic signed [ANGLE_W-1:0] ang   [2];
  logic signed [T_W-1:0]    t      [2];
  logic                     under  [2];
  logic                     over   [2];
  logic [TC_W-1:0]          tc     [2];
  logic [P_W-1:0]           p      [2];

  aph_tag_t                 s1_tag;
  logic [P_W-1:0]           s1_p     [2];
  logic                     s1_under [2];
  logic                     s1_over  [2];
  logic [NB_W-1:0]          s1_nb;
  logic [IDX_PORT_W-1:0]    s1_rrow;
  logic [IDX_PORT_W-1:0]    s1_rcol;

  logic [Q_W-1:0]           q       [2];
  logic [D_W-1:0]           prod    [2];
  logic [IDX_W-1:0]         idx_raw [2];
  logic [IDX_W-1:0]         idx     [2];
  logic [IDX_W-1:0]         last;
  logic [IDX_W-1:0]         row_sel;
  logic [IDX_W-1:0]         col_sel;

  // Clamp the bin count register to the usable range
  always_comb begin
    if (bin_count == '0) begin
      nb = NB_W'(1);
    end else if (int'(bin_count) > MAX_BINS) begin
      nb = NB_W'(MAX_BINS);
    end else begin
      nb = NB_W'(bin_count);
    end
    oob = (int'(read_row) >= MAX_BINS) || (int'(read_col) >= MAX_BINS);
  end

  // Offset each angle by a half turn and scale by the bin count
  assign ang[0] = angle_first;
  assign ang[1] = angle_second;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      t[i]     = T_W'(ang[i]) + T_W'(HALF);
      under[i] = t[i][T_W-1];
      over[i]  = !under[i] && (int'(t[i]) >= FULL);
      tc[i]    = (under[i] || over[i]) ? '0 : TC_W'(t[i]);
      p[i]     = P_W'(nb) * P_W'(tc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
    end else if (advance) begin
      s1_tag <= '{valid: load, op: op, oob: oob};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 2; i++) begin
        s1_p[i]     <= p[i];
        s1_under[i] <= under[i];
        s1_over[i]  <= over[i];
      end
      s1_nb   <= nb;
      s1_rrow <= read_row;
      s1_rcol <= read_col;
    end
  end

  // Divide by the full turn and clamp to the grid
  always_comb begin
    last = IDX_W'(s1_nb - NB_W'(1));
    for (int i = 0; i < 2; i++) begin
      q[i]       = Q_W'(s1_p[i] >> SH);
      prod[i]    = D_W'(q[i]) * D_W'(RECIP);
      idx_raw[i] = IDX_W'(prod[i] >> RECIP_SHIFT);
      if (s1_under[i]) begin
        idx[i] = '0;
      end else if (s1_over[i] || (NB_W'(idx_raw[i]) >= s1_nb)) begin
        idx[i] = last;
      end else begin
        idx[i] = idx_raw[i];
      end
    end
    if (s1_tag.op == OP_ADD) begin
      row_sel = idx[0];
      col_sel = idx[1];
    end else begin
      row_sel = IDX_W'(s1_rrow);
      col_sel = IDX_W'(s1_rcol);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else if (advance) begin
      tag <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      addr <= {row_sel, col_sel};
      if (s1_tag.op == OP_ADD) begin
        echo_row <= IDX_PORT_W'(idx[0]);
        echo_col <= IDX_PORT_W'(idx[1]);
      end else begin
        echo_row <= s1_rrow;
        echo_col <= s1_rcol;
      end
    end
  end

endmodule

// ----- src/aph_count_mem.sv -----
// Bin counter store: one write port, one registered read port, and a
// clearing sweep after reset that zeroes one entry per cycle.
module aph_count_mem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic              busy
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [ADDR_W-1:0] clr_addr;

  // Sweep every entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == '1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/angle_pair_2d_histogram_core.sv -----
// Two-dimensional histogram of angle pairs. An add word bins two angles
// (degrees, signed fixed point) into a square grid of bin_count cells per side
// and increments that cell; a read word returns one cell. Every word yields one
// result with the cell count, the peak cell count, the sample total, the sum of
// squared counts and a sticky saturation flag. Results pass the bin-map stages,
// the cell read and the output register, and one word per cycle is taken while
// results drain: the counters live in a single-port-read, single-port-write
// memory updated by a read-modify-write with forwarding from the last write.
// After reset all 2^(2*ceil(log2(MAX_BINS))) memory entries (4096 for 64 bins)
// are swept clear; req.ready stays low during the sweep while configuration
// writes are taken. Write bin_count only while no word is in flight.
module angle_pair_2d_histogram_core import aph_pkg::*; #(
  parameter int MAX_BINS        = 64,
  parameter int COUNT_WIDTH     = 20,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic      clk,
  input  logic      rst,
  aph_cfg_if.sink   cfg,
  aph_req_if.sink   req,
  aph_rsp_if.source rsp
);

  localparam int IDX_W  = $clog2(MAX_BINS);
  localparam int NB_W   = $clog2(MAX_BINS + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                   advance;
  logic                   accept;
  logic                   step;
  logic                   mem_busy;
  logic [CFG_W-1:0]       bin_count;

  aph_tag_t               s2_tag;
  logic [ADDR_W-1:0]      s2_addr;
  logic [IDX_PORT_W-1:0]  s2_row;
  logic [IDX_PORT_W-1:0]  s2_col;

  aph_tag_t               s3_tag;
  logic [ADDR_W-1:0]      s3_addr;
  logic [IDX_PORT_W-1:0]  s3_row;
  logic [IDX_PORT_W-1:0]  s3_col;
  logic [COUNT_WIDTH-1:0] rd_data;

  logic                   lw_valid;
  logic [ADDR_W-1:0]      lw_addr;
  logic [COUNT_WIDTH-1:0] lw_data;

  logic [COUNT_WIDTH-1:0] peak;
  logic [COUNT_WIDTH-1:0] total;
  logic [SQ_W-1:0]        sq;
  logic                   flag;

  logic [COUNT_WIDTH-1:0] cur;
  logic                   cell_full;
  logic [COUNT_WIDTH-1:0] c_new;
  logic [SQ_W-1:0]        inc;
  logic [COUNT_WIDTH-1:0] peak_next;
  logic [COUNT_WIDTH-1:0] total_next;
  logic [SQ_W-1:0]        sq_next;
  logic                   flag_next;
  logic [COUNT_WIDTH-1:0] value;
  logic                   wr_en;

  logic                   rsp_valid;
  logic [IDX_PORT_W-1:0]  rsp_row;
  logic [IDX_PORT_W-1:0]  rsp_col;
  logic [COUNT_WIDTH-1:0] rsp_value;
  logic [COUNT_WIDTH-1:0] rsp_peak;
  logic [COUNT_WIDTH-1:0] rsp_total;
  logic [SQ_W-1:0]        rsp_sq;
  logic                   rsp_flag;

  // Advance the whole pipeline whenever the output register can take a word
  assign advance   = !rsp_valid || rsp.ready;
  assign req.ready = advance && !mem_busy;
  assign accept    = req.valid && req.ready;
  assign step      = advance && s3_tag.valid;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= BIN_COUNT_RESET;
    end else if (cfg.valid) begin
      bin_count <= cfg.bin_count;
    end
  end

  aph_bin_map #(
    .MAX_BINS        (MAX_BINS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .IDX_W           (IDX_W),
    .NB_W            (NB_W)
  ) u_bin_map (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .load         (accept),
    .op           (req.op),
    .angle_first  (req.angle_first),
    .angle_second (req.angle_second),
    .read_row     (req.read_row),
    .read_col     (req.read_col),
    .bin_count    (bin_count),
    .tag          (s2_tag),
    .addr         (s2_addr),
    .echo_row     (s2_row),
    .echo_col     (s2_col)
  );

  aph_count_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_WIDTH)
  ) u_count_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (advance),
    .rd_addr (s2_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s3_addr),
    .wr_data (c_new),
    .busy    (mem_busy)
  );

  // Hold the word whose cell read is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag <= '0;
    end else if (advance) begin
      s3_tag <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_addr <= s2_addr;
      s3_row  <= s2_row;
      s3_col  <= s2_col;
    end
  end

  // Modify: forward the last write, increment with saturation, update totals
  always_comb begin
    cur        = (lw_valid && (lw_addr == s3_addr)) ? lw_data : rd_data;
    cell_full  = (cur == CNT_MAX);
    inc        = SQ_W'({cur, 1'b1});
    c_new      = cur;
    peak_next  = peak;
    total_next = total;
    sq_next    = sq;
    flag_next  = flag;
    value      = cur;
    if (s3_tag.op == OP_ADD) begin
      if (cell_full) begin
        flag_next = 1'b1;
      end else begin
        c_new = cur + COUNT_WIDTH'(1);
        if (sq > (SQ_MAX - inc)) begin
          sq_next   = SQ_MAX;
          flag_next = 1'b1;
        end else begin
          sq_next = sq + inc;
        end
      end
      if (c_new > peak) begin
        peak_next = c_new;
      end
      if (total == CNT_MAX) begin
        flag_next = 1'b1;
      end else begin
        total_next = total + COUNT_WIDTH'(1);
      end
      value = c_new;
    end else if (s3_tag.oob) begin
      value = '0;
    end
  end

  assign wr_en = step && (s3_tag.op == OP_ADD) && !cell_full;

  // Track the last write for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (wr_en) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr <= s3_addr;
      lw_data <= c_new;
    end
  end

  // Running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      peak  <= '0;
      total <= '0;
      sq    <= '0;
      flag  <= 1'b0;
    end else if (step) begin
      peak  <= peak_next;
      total <= total_next;
      sq    <= sq_next;
      flag  <= flag_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s3_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_row   <= s3_row;
      rsp_col   <= s3_col;
      rsp_value <= value;
      rsp_peak  <= peak_next;
      rsp_total <= total_next;
      rsp_sq    <= sq_next;
      rsp_flag  <= flag_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.bin_row       = rsp_row;
  assign rsp.bin_col       = rsp_col;
  assign rsp.bin_value     = rsp_value;
  assign rsp.peak_count    = rsp_peak;
  assign rsp.total_samples = rsp_total;
  assign rsp.square_sum    = rsp_sq;
  assign rsp.overflow      = rsp_flag;

endmodule

// ----- src/aph_checker.sv -----
module aph_checker #(
  parameter int COUNT_WIDTH = 20
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [COUNT_WIDTH-1:0] bin_value,
  input logic [COUNT_WIDTH-1:0] peak_count,
  input logic [COUNT_WIDTH-1:0] total_samples,
  input logic                   overflow
);

  // Hold off input words while the store is swept after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("input taken during clearing sweep");

  // Hold a stalled result word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(bin_value) && $stable(total_samples))
    else $error("stalled result changed");

  // No cell exceeds the peak count
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> bin_value <= peak_count)
    else $error("cell count above peak");

  // Sample total never drops between results
  a_total_monotone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && $past(rsp_valid) |-> total_samples >= $past(total_samples))
    else $error("sample total decreased");

  // Saturation flag is sticky
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && $past(rsp_valid) && $past(overflow) |-> overflow)
    else $error("overflow flag cleared");

endmodule

bind angle_pair_2d_histogram_core aph_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_aph_checker (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .bin_value     (rsp.bin_value),
  .peak_count    (rsp.peak_count),
  .total_samples (rsp.total_samples),
  .overflow      (rsp.overflow)
);

// ----- verif/angle_pair_2d_histogram_core_tb.sv -----
`timescale 1ns / 1ps

module angle_pair_2d_histogram_core_tb;
  import aph_pkg::*;

  localparam int     MAX_BINS    = 64;
  localparam int     CNT_W       = 20;
  localparam int     FRAC_BITS   = 7;
  localparam int     CELLS       = MAX_BINS * MAX_BINS;
  localparam longint CNT_TOP     = (64'd1 << CNT_W) - 1;
  localparam longint SQ_TOP      = (64'd1 << SQ_W) - 1;
  localparam longint HALF_SPAN   = longint'(HALF_TURN_DEG) << FRAC_BITS;
  localparam longint FULL_SPAN   = longint'(FULL_TURN_DEG) << FRAC_BITS;
  localparam int     PIPE_SETTLE = 8;
  localparam int     HOLD_AT     = 100;
  localparam int     HOLD_CYCLES = 300;

  typedef struct {
    aph_op_t                   op;
    logic signed [ANGLE_W-1:0] angle_a;
    logic signed [ANGLE_W-1:0] angle_b;
    logic [IDX_PORT_W-1:0]     row;
    logic [IDX_PORT_W-1:0]     col;
  } sample_word_t;

  typedef struct {
    logic [IDX_PORT_W-1:0] row;
    logic [IDX_PORT_W-1:0] col;
    logic [CNT_W-1:0]      value;
    logic [CNT_W-1:0]      peak;
    logic [CNT_W-1:0]      total;
    logic [SQ_W-1:0]       squares;
    logic                  sat;
  } bin_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aph_cfg_if                       cfg_if ();
  aph_req_if                       req_if ();
  aph_rsp_if #(.COUNT_WIDTH(CNT_W)) rsp_if ();

  angle_pair_2d_histogram_core #(
    .MAX_BINS       (MAX_BINS),
    .COUNT_WIDTH    (CNT_W),
    .ANGLE_FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_if),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #1 clk = ~clk;

  // Histogram state as the block should hold it
  logic [CNT_W-1:0] cell_count [CELLS];
  logic [CNT_W-1:0] peak_seen;
  logic [CNT_W-1:0] samples_seen;
  logic [SQ_W-1:0]  square_acc;
  logic             sat_seen;
  logic [CFG_W-1:0] grid_cfg;

  sample_word_t pending_words [$];
  bin_report_t  expected_reports [$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int words_out;
  int hold_left;
  bit hold_done;

  function automatic int grid_size(logic [CFG_W-1:0] setting);
    int n;
    n = int'(setting);
    if (n == 0) n = 1;
    if (n > MAX_BINS) n = MAX_BINS;
    return n;
  endfunction

  function automatic int angle_to_bin(logic signed [ANGLE_W-1:0] angle, int n);
    longint shifted;
    longint idx;
    shifted = longint'(angle) + HALF_SPAN;
    if (shifted < 0) return 0;
    idx = (longint'(n) * shifted) / FULL_SPAN;
    if (idx >= n) idx = n - 1;
    return int'(idx);
  endfunction

  // Apply one word to the histogram state and return the report it yields
  function automatic bin_report_t histogram_apply(sample_word_t w);
    bin_report_t r;
    int          n;
    int          row;
    int          col;
    longint      c;
    longint      step;
    if (w.op == OP_ADD) begin
      n = grid_size(grid_cfg);
      row = angle_to_bin(w.angle_a, n);
      col = angle_to_bin(w.angle_b, n);
      c = longint'(cell_count[row * MAX_BINS + col]);
      if (c >= CNT_TOP) begin
        sat_seen = 1'b1;
      end else begin
        step = 2 * c + 1;
        if (longint'(square_acc) > SQ_TOP - step) begin
          square_acc = SQ_TOP[SQ_W-1:0];
          sat_seen = 1'b1;
        end else begin
          square_acc = square_acc + step[SQ_W-1:0];
        end
        c = c + 1;
        cell_count[row * MAX_BINS + col] = c[CNT_W-1:0];
      end
      if (c > longint'(peak_seen)) peak_seen = c[CNT_W-1:0];
      if (longint'(samples_seen) >= CNT_TOP) sat_seen = 1'b1;
      else samples_seen = samples_seen + 1'b1;
      r.value = c[CNT_W-1:0];
    end else begin
      row = int'(w.row);
      col = int'(w.col);
      if (row < MAX_BINS && col < MAX_BINS) r.value = cell_count[row * MAX_BINS + col];
      else r.value = '0;
    end
    r.row = row[IDX_PORT_W-1:0];
    r.col = col[IDX_PORT_W-1:0];
    r.peak = peak_seen;
    r.total = samples_seen;
    r.squares = square_acc;
    r.sat = sat_seen;
    return r;
  endfunction

  // Angle mix: in range, full 16-bit, range ends, and both sides of bin edges
  function automatic logic signed [ANGLE_W-1:0] random_angle(int n);
    longint k;
    longint boundary;
    case ($urandom_range(0, 9))
      0: return ANGLE_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return ANGLE_W'(-HALF_SPAN);
          1: return ANGLE_W'(HALF_SPAN);
          2: return ANGLE_W'(-HALF_SPAN - 1);
          default: return ANGLE_W'(HALF_SPAN - 1);
        endcase
      end
      2, 3: begin
        k = $urandom_range(0, n);
        boundary = (k * FULL_SPAN + n - 1) / n - HALF_SPAN;
        return ANGLE_W'(boundary - longint'($urandom_range(0, 1)));
      end
      default: return ANGLE_W'(longint'($urandom_range(0, FULL_SPAN)) - HALF_SPAN);
    endcase
  endfunction

  function automatic sample_word_t random_word(int n);
    sample_word_t w;
    w.angle_a = random_angle(n);
    w.angle_b = random_angle(n);
    w.row = IDX_PORT_W'($urandom);
    w.col = IDX_PORT_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      w.op = OP_READ;
      // Mostly read cells inside the live grid, where counts build up
      if ($urandom_range(0, 9) < 7) begin
        w.row = IDX_PORT_W'($urandom_range(0, n - 1));
        w.col = IDX_PORT_W'($urandom_range(0, n - 1));
      end
    end else begin
      w.op = OP_ADD;
    end
    return w;
  endfunction

  function automatic void push_add(int a, int b);
    sample_word_t w;
    w.op = OP_ADD;
    w.angle_a = ANGLE_W'(a);
    w.angle_b = ANGLE_W'(b);
    w.row = IDX_PORT_W'($urandom);
    w.col = IDX_PORT_W'($urandom);
    pending_words.push_back(w);
  endfunction

  function automatic void push_read(int r, int c);
    sample_word_t w;
    w.op = OP_READ;
    w.angle_a = ANGLE_W'($urandom);
    w.angle_b = ANGLE_W'($urandom);
    w.row = IDX_PORT_W'(r);
    w.col = IDX_PORT_W'(c);
    pending_words.push_back(w);
  endfunction

  task automatic note_mismatch(string field, longint want, longint got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  task automatic write_grid(logic [CFG_W-1:0] setting);
    @(posedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.bin_count <= setting;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until no word is queued, offered or owed a result; sample between edges
  task automatic drain_all();
    do @(negedge clk);
    while (pending_words.size() != 0 || req_if.valid || expected_reports.size() != 0);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] setting, int count, int idle, int stall);
    int n;
    drain_all();
    write_grid(setting);
    @(posedge clk);
    send_idle_pct  <= idle;
    recv_stall_pct <= stall;
    n = grid_size(setting);
    for (int i = 0; i < count; i++) pending_words.push_back(random_word(n));
  endtask

  // Offer words from the queue; hold each one until it is taken
  always @(posedge clk) begin : drive_req
    sample_word_t w;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        req_if.valid        <= 1'b1;
        req_if.op           <= w.op;
        req_if.angle_first  <= w.angle_a;
        req_if.angle_second <= w.angle_b;
        req_if.read_row     <= w.row;
        req_if.read_col     <= w.col;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Track accepted configuration and words, predict each report
  always @(posedge clk) begin : track_inputs
    sample_word_t w;
    if (!rst && cfg_if.valid && cfg_if.ready) grid_cfg = cfg_if.bin_count;
    if (!rst && req_if.valid && req_if.ready) begin
      w.op      = req_if.op;
      w.angle_a = req_if.angle_first;
      w.angle_b = req_if.angle_second;
      w.row     = req_if.read_row;
      w.col     = req_if.read_col;
      expected_reports.push_back(histogram_apply(w));
    end
  end

  // Drive result ready: random stalls plus one long hold-off
  always @(posedge clk) begin : drive_rsp_ready
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) words_out <= words_out + 1;
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (!hold_done && words_out >= HOLD_AT) begin
        rsp_if.ready <= 1'b0;
        hold_done    <= 1'b1;
        hold_left    <= HOLD_CYCLES;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    bin_report_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: row %0d col %0d value %0d",
                   rsp_if.bin_row, rsp_if.bin_col, rsp_if.bin_value);
      end else begin
        want = expected_reports.pop_front();
        if (rsp_if.bin_row !== want.row) note_mismatch("bin_row", want.row, rsp_if.bin_row);
        if (rsp_if.bin_col !== want.col) note_mismatch("bin_col", want.col, rsp_if.bin_col);
        if (rsp_if.bin_value !== want.value)
          note_mismatch("bin_value", want.value, rsp_if.bin_value);
        if (rsp_if.peak_count !== want.peak)
          note_mismatch("peak_count", want.peak, rsp_if.peak_count);
        if (rsp_if.total_samples !== want.total)
          note_mismatch("total_samples", want.total, rsp_if.total_samples);
        if (rsp_if.square_sum !== want.squares)
          note_mismatch("square_sum", want.squares, rsp_if.square_sum);
        if (rsp_if.overflow !== want.sat)
          note_mismatch("overflow", want.sat, rsp_if.overflow);
      end
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    foreach (cell_count[i]) cell_count[i] = '0;
    peak_seen    = '0;
    samples_seen = '0;
    square_acc   = '0;
    sat_seen     = 1'b0;
    grid_cfg     = BIN_COUNT_RESET;
    fail_count   = 0;
    words_out    = 0;
    hold_left    = 0;
    hold_done    = 1'b0;

    // Known values on every input before the first edge
    cfg_if.valid        = 1'b0;
    cfg_if.bin_count    = '0;
    req_if.valid        = 1'b0;
    req_if.op           = OP_ADD;
    req_if.angle_first  = '0;
    req_if.angle_second = '0;
    req_if.read_row     = '0;
    req_if.read_col     = '0;
    rsp_if.ready        = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed words on the full 64-bin grid: range ends, clamps, bin edges
    write_grid(7'd64);
    push_add(-23040, -23040);
    push_add(23040, 23040);
    push_add(-32768, 32767);
    push_add(32767, -32768);
    push_add(-23041, 23039);
    push_add(0, -1);
    push_add(-22320, -22321);
    push_add(0, 0);
    push_add(0, 0);
    push_add(0, 0);
    push_add(21845, -21846);
    push_read(0, 0);
    push_read(63, 63);
    push_read(32, 32);
    push_read(1, 0);
    push_read(63, 0);
    push_read(0, 63);
    push_read(62, 1);
    push_read(5, 40);
    push_read(32, 31);

    // Bin count above the maximum, then zero; the long receiver hold lands early
    run_phase(7'd127, 500, 0, 0);
    run_phase(7'd0, 60, 85, 0);
    run_phase(7'($urandom_range(2, 63)), 500, 85, 0);
    run_phase(7'd1, 60, 0, 85);
    run_phase(7'd36, 500, 0, 85);
    run_phase(7'($urandom_range(2, 9)), 450, 24, 24);

    drain_all();
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
